// File: rtl/lsbsd_pkg.sv
`default_nettype none

package lsbsd_pkg;

   localparam int LENGTH_BITS_DEFAULT = 32;

   localparam logic [15:0] HEADER_SKIP_RESET = 16'd54;
   localparam logic [15:0] MAGIC_WORD_RESET  = 16'h232A;   // '#' then '*'

   localparam int CSR_DATA_W = 16;

   typedef enum logic [0:0] {
      CSR_HEADER_SKIP = 1'b0,
      CSR_MAGIC_WORD  = 1'b1
   } csr_index_type;

   typedef enum logic [7:0] {
      PH_HEADER  = 8'b0000_0001,
      PH_MAGIC   = 8'b0000_0010,
      PH_EXT_LEN = 8'b0000_0100,
      PH_EXT     = 8'b0000_1000,
      PH_PAY_LEN = 8'b0001_0000,
      PH_PAY     = 8'b0010_0000,
      PH_DONE    = 8'b0100_0000,
      PH_HALT    = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic                  valid;
      csr_index_type         index;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_section;
      logic       out_last;
      logic       status;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/lsbsd_if.sv
`default_nettype none

interface lsbsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;

   modport source (output valid, output pixel_byte, input ready);
   modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface lsbsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_section;
   logic       out_last;
   logic       status;

   modport source (output valid, output out_byte, output out_section, output out_last,
                   output status, input ready);
   modport sink   (input valid, input out_byte, input out_section, input out_last,
                   input status, output ready);
endinterface

interface lsbsd_csr_if
   import lsbsd_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/lsbsd_in_stage.sv
`default_nettype none

module lsbsd_in_stage
   import lsbsd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   lsbsd_req_if.sink   req,
   input  wire logic   out_free,
   output logic        step,
   output logic        data_bit
);

   logic valid_ff, valid_in;
   logic bit_ff;
   logic take;

   // the held beat moves on only when the result register can take its outcome
   assign step     = valid_ff && out_free;
   assign req.ready = !valid_ff || step;
   assign take     = req.valid && req.ready;
   assign valid_in = take || (valid_ff && !step);
   assign data_bit = bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         bit_ff <= req.pixel_byte[0];
      end
   end

endmodule

`default_nettype wire

// File: rtl/lsbsd_core.sv
`default_nettype none

module lsbsd_core
   import lsbsd_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire logic          data_bit,
   input  wire csr_write_type csr_wr,
   input  wire logic [15:0]   magic_word,
   output logic               produce,
   output result_type         result
);

   localparam int CNT_W = $clog2(LENGTH_BITS);

   phase_type               phase_ff, phase_in;
   logic [15:0]             header_left_ff, header_left_in;
   logic [CNT_W-1:0]        bit_count_ff, bit_count_in;
   logic [LENGTH_BITS-1:0]  bit_shift_ff, bit_shift_in;
   logic [LENGTH_BITS-1:0]  bytes_left_ff, bytes_left_in;
   logic                    magic_index_ff, magic_index_in;

   logic [LENGTH_BITS-1:0]  shifted;
   logic [LENGTH_BITS-1:0]  bytes_dec;
   logic [15:0]             header_dec;
   logic [7:0]              expect_byte;
   logic                    unit_done;

   assign shifted     = {bit_shift_ff[LENGTH_BITS-2:0], data_bit};
   assign bytes_dec   = bytes_left_ff - LENGTH_BITS'(1);
   assign header_dec  = (header_left_ff != 16'd0) ? header_left_ff - 16'd1 : header_left_ff;
   assign expect_byte = magic_index_ff ? magic_word[7:0] : magic_word[15:8];

   always_comb begin
      phase_in       = phase_ff;
      header_left_in = header_left_ff;
      bit_count_in   = bit_count_ff;
      bit_shift_in   = bit_shift_ff;
      bytes_left_in  = bytes_left_ff;
      magic_index_in = magic_index_ff;
      produce        = 1'b0;
      result         = '0;
      unit_done      = 1'b0;

      if (csr_wr.valid && csr_wr.index == CSR_HEADER_SKIP) begin
         // skip count restarts only while still in the header
         if (phase_ff == PH_HEADER) begin
            header_left_in = csr_wr.data;
            if (csr_wr.data == 16'd0) begin
               phase_in = PH_MAGIC;
            end
         end
      end else if (step) begin
         case (phase_ff)
            PH_HEADER: begin
               header_left_in = header_dec;
               if (header_dec == 16'd0) begin
                  phase_in = PH_MAGIC;
               end
            end
            PH_MAGIC, PH_EXT, PH_PAY, PH_EXT_LEN, PH_PAY_LEN: begin
               if (phase_ff inside {PH_EXT_LEN, PH_PAY_LEN}) begin
                  unit_done = (bit_count_ff == CNT_W'(LENGTH_BITS - 1));
               end else begin
                  unit_done = (bit_count_ff == CNT_W'(7));
               end
               if (!unit_done) begin
                  bit_count_in = bit_count_ff + CNT_W'(1);
                  bit_shift_in = shifted;
               end else begin
                  bit_count_in = '0;
                  bit_shift_in = '0;
                  case (phase_ff)
                     PH_MAGIC: begin
                        if (shifted[7:0] != expect_byte) begin
                           phase_in           = PH_HALT;
                           produce            = 1'b1;
                           result.status      = 1'b1;
                        end else if (!magic_index_ff) begin
                           magic_index_in = 1'b1;
                        end else begin
                           magic_index_in = 1'b0;
                           phase_in       = PH_EXT_LEN;
                        end
                     end
                     PH_EXT_LEN: begin
                        bytes_left_in = shifted;
                        phase_in      = (shifted == '0) ? PH_PAY_LEN : PH_EXT;
                     end
                     PH_PAY_LEN: begin
                        bytes_left_in = shifted;
                        phase_in      = (shifted == '0) ? PH_DONE : PH_PAY;
                     end
                     default: begin
                        bytes_left_in      = bytes_dec;
                        produce            = 1'b1;
                        result.out_byte    = shifted[7:0];
                        result.out_section = (phase_ff == PH_PAY);
                        result.out_last    = (bytes_dec == '0);
                        if (bytes_dec == '0) begin
                           phase_in = (phase_ff == PH_PAY) ? PH_DONE : PH_PAY_LEN;
                        end
                     end
                  endcase
               end
            end
            default: begin
               // done or halted: beats are swallowed
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         header_left_ff <= HEADER_SKIP_RESET;
         bit_count_ff   <= '0;
         bit_shift_ff   <= '0;
         bytes_left_ff  <= '0;
         magic_index_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         header_left_ff <= header_left_in;
         bit_count_ff   <= bit_count_in;
         bit_shift_ff   <= bit_shift_in;
         bytes_left_ff  <= bytes_left_in;
         magic_index_ff <= magic_index_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lsbsd_out_stage.sv
`default_nettype none

module lsbsd_out_stage
   import lsbsd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   lsbsd_rsp_if.source     rsp,
   input  wire logic       step,
   input  wire logic       produce,
   input  wire result_type result,
   output logic            out_free
);

   logic       valid_ff, valid_in;
   result_type data_ff;
   logic       load;

   assign out_free = !valid_ff || rsp.ready;
   assign load     = step && produce;
   assign valid_in = load || (valid_ff && !rsp.ready);

   assign rsp.valid       = valid_ff;
   assign rsp.out_byte    = data_ff.out_byte;
   assign rsp.out_section = data_ff.out_section;
   assign rsp.out_last    = data_ff.out_last;
   assign rsp.status      = data_ff.status;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lsb_stego_stream_decoder.sv
// LSB steganography stream decoder.
// req: one image beat per item (pixel_byte); only bit 0 carries hidden data.
// rsp: one beat per recovered extension or payload byte, with section and
//   last marks, or a single error beat (status high, other fields zero) on a
//   magic mismatch, after which the decoder halts until reset.
// csr: write-only; index 0 header_skip, index 1 magic_word. Always ready.
//   Writes are expected only while the block is idle.
// Path: an accepted beat waits in the input register until the result register
//   is free, then is decoded into the result register, where rsp.valid rises.
// Throughput: one image beat per cycle while the result register is free, set by
//   the input register feeding a single decode step into the result register.
// Stall: while a result waits in the result register, one further beat is
//   held in the input register; req.ready then drops until rsp takes a beat.
// Reset (synchronous, active high): header_skip back to 54, magic_word back
//   to '#','*', decoder returns to header skipping, both registers emptied.
`default_nettype none

module lsb_stego_stream_decoder
   import lsbsd_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
)
(
   input  wire logic   clock,
   input  wire logic   reset,
   lsbsd_req_if.sink   req,
   lsbsd_rsp_if.source rsp,
   lsbsd_csr_if.sink   csr
);

   logic          step;
   logic          data_bit;
   logic          out_free;
   logic          produce;
   result_type    result;
   csr_write_type csr_wr;
   logic [15:0]   magic_word_ff, magic_word_in;

   // config port never back-pressures
   assign csr.ready    = 1'b1;
   assign csr_wr.valid = csr.valid;
   assign csr_wr.index = csr.index;
   assign csr_wr.data  = csr.data;

   // header_skip acts on the core's skip counter directly; only the magic is kept here
   assign magic_word_in = (csr.valid && csr.index == CSR_MAGIC_WORD) ? csr.data
                                                                    : magic_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_word_ff <= MAGIC_WORD_RESET;
      end else begin
         magic_word_ff <= magic_word_in;
      end
   end

   lsbsd_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .out_free (out_free),
      .step     (step),
      .data_bit (data_bit)
   );

   lsbsd_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .data_bit   (data_bit),
      .csr_wr     (csr_wr),
      .magic_word (magic_word_ff),
      .produce    (produce),
      .result     (result)
   );

   lsbsd_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .rsp      (rsp),
      .step     (step),
      .produce  (produce),
      .result   (result),
      .out_free (out_free)
   );

endmodule

`default_nettype wire

// File: rtl/lsbsd_checker.sv
`default_nettype none

module lsbsd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_out_section,
   input wire logic       rsp_out_last,
   input wire logic       rsp_status,
   input wire logic       csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_out_byte == 8'd0 && !rsp_out_section && !rsp_out_last)
      else $error("error beat carries data");

   a_halt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_status |=> !rsp_valid)
      else $error("beat after error");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty result register");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid || !req_valid |-> csr_ready)
      else $error("csr back-pressured");

endmodule

bind lsb_stego_stream_decoder lsbsd_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_out_byte    (rsp.out_byte),
   .rsp_out_section (rsp.out_section),
   .rsp_out_last    (rsp.out_last),
   .rsp_status      (rsp.status),
   .csr_ready       (csr.ready)
);

`default_nettype wire

// File: verif/tb_lsb_stego_stream_decoder.sv
`timescale 1ns / 1ps

// Self-checking bench for the LSB stego stream decoder.
// One frame per run (the decoder only restarts on reset, and reset is applied
// once), so the frame shape is drawn from the seed: a magic mismatch, an empty
// extension, an empty payload, an unbounded payload length, or a full frame.
module tb_lsb_stego_stream_decoder;
   import lsbsd_pkg::*;

   localparam int          LEN_W         = LENGTH_BITS_DEFAULT;
   localparam logic [31:0] LEN_MASK      = (LEN_W >= 32) ? 32'hFFFF_FFFF
                                                         : ((32'd1 << LEN_W) - 32'd1);
   localparam int          RESET_CYCLES  = 11;
   // input register plus result register, with margin
   localparam int          SETTLE_CYCLES = 8;
   localparam int          LONG_HOLD     = 400;
   localparam int          CYCLE_LIMIT   = 400000;

   // traffic shaping on both channels, rotated through during the run
   typedef enum logic [1:0] {
      TRAFFIC_FREE           = 2'd0,
      TRAFFIC_SENDER_IDLE    = 2'd1,
      TRAFFIC_RECEIVER_STALL = 2'd2,
      TRAFFIC_BOTH           = 2'd3
   } traffic_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lsbsd_req_if req ();
   lsbsd_rsp_if rsp ();
   lsbsd_csr_if csr ();

   lsb_stego_stream_decoder #(.LENGTH_BITS(LEN_W)) dut (
      .clock(clock),
      .reset(reset),
      .req  (req),
      .rsp  (rsp),
      .csr  (csr)
   );

   always #10 clock = ~clock;

   // image beats waiting to be offered, and decoded beats still owed by the DUT
   logic [7:0]  pixel_fifo[$];
   result_type  awaited_bytes[$];

   traffic_type traffic = TRAFFIC_FREE;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   logic        freeze_start = 1'b0;
   int unsigned freeze_left  = 0;
   logic        hold_done    = 1'b0;

   int unsigned pushed_beats   = 0;
   int unsigned accepted_beats = 0;
   int unsigned checked_bytes  = 0;
   int unsigned error_beats    = 0;
   int unsigned stalled_cycles = 0;
   int unsigned fails          = 0;
   int unsigned cycle_count    = 0;

   // decoder mirror: registers and state
   logic [15:0] skip_reg;
   logic [15:0] magic_reg;
   logic [15:0] skip_left;
   phase_type   dec_phase;
   logic [4:0]  nbits;
   logic [31:0] gathered;
   logic [31:0] remaining;
   logic        second_magic;

   assign send_idle_pct  = (traffic == TRAFFIC_SENDER_IDLE)    ? 63 :
                           (traffic == TRAFFIC_BOTH)           ? 13 : 0;
   assign recv_stall_pct = (traffic == TRAFFIC_RECEIVER_STALL) ? 63 :
                           (traffic == TRAFFIC_BOTH)           ? 13 : 0;

   // ---------------------------------------------------------------------
   // Mirror of the decoder
   // ---------------------------------------------------------------------

   // Register write as the decoder sees it: a new skip count only restarts
   // the skip while the header is still being skipped.
   task automatic mirror_csr_write(input csr_index_type idx, input logic [15:0] val);
      case (idx)
         CSR_HEADER_SKIP: begin
            skip_reg = val;
            if (dec_phase == PH_HEADER) begin
               skip_left = val;
               if (val == 16'd0) dec_phase = PH_MAGIC;
            end
         end
         CSR_MAGIC_WORD: magic_reg = val;
         default: ;
      endcase
   endtask

   // One image beat in; queues the decoded beat it gives rise to, if any.
   task automatic decode_pixel(input logic [7:0] pixel);
      int unsigned unit_w;
      logic [31:0] word;
      logic [7:0]  want_magic;
      logic        is_payload;
      result_type  r;
      unit_w = 0;
      case (dec_phase)
         PH_HEADER: begin
            if (skip_left != 16'd0) skip_left = skip_left - 16'd1;
            if (skip_left == 16'd0) dec_phase = PH_MAGIC;
         end
         PH_MAGIC, PH_EXT, PH_PAY: unit_w = 8;
         PH_EXT_LEN, PH_PAY_LEN:   unit_w = LEN_W;
         default: ;   // done or halted: beat ignored
      endcase
      if (unit_w != 0) begin
         gathered = {gathered[30:0], pixel[0]};
         if (nbits + 1 < unit_w) begin
            nbits = nbits + 5'd1;
         end else begin
            word     = gathered;
            nbits    = '0;
            gathered = '0;
            case (dec_phase)
               PH_MAGIC: begin
                  want_magic = second_magic ? magic_reg[7:0] : magic_reg[15:8];
                  if (word[7:0] != want_magic) begin
                     dec_phase = PH_HALT;
                     r = '0;
                     r.status = 1'b1;
                     awaited_bytes.push_back(r);
                  end else if (!second_magic) begin
                     second_magic = 1'b1;
                  end else begin
                     second_magic = 1'b0;
                     dec_phase    = PH_EXT_LEN;
                  end
               end
               PH_EXT_LEN: begin
                  remaining = word & LEN_MASK;
                  dec_phase = (remaining == 0) ? PH_PAY_LEN : PH_EXT;
               end
               PH_PAY_LEN: begin
                  remaining = word & LEN_MASK;
                  dec_phase = (remaining == 0) ? PH_DONE : PH_PAY;
               end
               default: begin
                  is_payload    = (dec_phase == PH_PAY);
                  remaining     = remaining - 32'd1;
                  r.out_byte    = word[7:0];
                  r.out_section = is_payload;
                  r.out_last    = (remaining == 0);
                  r.status      = 1'b0;
                  if (remaining == 0) dec_phase = is_payload ? PH_DONE : PH_PAY_LEN;
                  awaited_bytes.push_back(r);
               end
            endcase
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Image beat driver: next beat goes out once the current one is taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req.valid      <= 1'b0;
         req.pixel_byte <= 8'h00;
      end else if (!req.valid || req.ready) begin
         if (pixel_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req.valid      <= 1'b1;
            req.pixel_byte <= pixel_fifo.pop_front();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Result sink: random stalls, or held off entirely during a freeze
   always @(posedge clock) begin
      if (reset)                rsp.ready <= 1'b0;
      else if (freeze_left != 0) rsp.ready <= 1'b0;
      else                      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Long hold-off on the result side, counted here in cycles
   always @(posedge clock) begin
      if (reset)                 freeze_left <= 0;
      else if (freeze_start)     freeze_left <= LONG_HOLD;
      else if (freeze_left != 0) freeze_left <= freeze_left - 1;
   end

   // ---------------------------------------------------------------------
   // Monitor: register writes and image beats feed the mirror, result
   // beats are checked in order against what it predicted
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      result_type want;
      if (reset) begin
         skip_reg     = HEADER_SKIP_RESET;
         magic_reg    = MAGIC_WORD_RESET;
         skip_left    = HEADER_SKIP_RESET;
         dec_phase    = (HEADER_SKIP_RESET == 16'd0) ? PH_MAGIC : PH_HEADER;
         nbits        = '0;
         gathered     = '0;
         remaining    = '0;
         second_magic = 1'b0;
      end else begin
         if (csr.valid && csr.ready) mirror_csr_write(csr.index, csr.data);
         if (req.valid && req.ready) begin
            decode_pixel(req.pixel_byte);
            accepted_beats++;
         end
         if (freeze_left != 0 && req.valid && !req.ready) stalled_cycles++;
         if (rsp.valid && rsp.ready) begin
            if (awaited_bytes.size() == 0) begin
               $error("result beat with none expected: byte %0h section %0b last %0b status %0b",
                      rsp.out_byte, rsp.out_section, rsp.out_last, rsp.status);
               fails++;
            end else begin
               want = awaited_bytes.pop_front();
               if (rsp.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", want.out_byte, rsp.out_byte);
                  fails++;
               end
               if (rsp.out_section !== want.out_section) begin
                  $error("out_section: expected %0b, got %0b", want.out_section,
                         rsp.out_section);
                  fails++;
               end
               if (rsp.out_last !== want.out_last) begin
                  $error("out_last: expected %0b, got %0b", want.out_last, rsp.out_last);
                  fails++;
               end
               if (rsp.status !== want.status) begin
                  $error("status: expected %0b, got %0b", want.status, rsp.status);
                  fails++;
               end
               if (want.status) error_beats++;
               else             checked_bytes++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("timed out after %0d cycles, %0d result beats outstanding",
                cycle_count, awaited_bytes.size());
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_raw(input logic [7:0] px);
      pixel_fifo.push_back(px);
      pushed_beats++;
   endtask

   // hidden bit in bit 0, random filler above it
   task automatic push_pixel(input logic hidden);
      logic [7:0] px;
      px    = $urandom;
      px[0] = hidden;
      push_raw(px);
   endtask

   // MSB first, one hidden bit per image beat
   task automatic push_bits(input logic [31:0] value, input int width);
      for (int i = width - 1; i >= 0; i--) push_pixel(value[i]);
   endtask

   task automatic push_noise(input int n);
      logic [7:0] px;
      repeat (n) begin
         px = $urandom;
         push_raw(px);
      end
   endtask

   // let the current traffic pattern run out, then move to the next one
   task automatic rotate_traffic();
      while (pixel_fifo.size() != 0) @(posedge clock);
      traffic = traffic_type'(traffic + 2'd1);
   endtask

   // Section body: first byte all zeros, last all ones, random in between.
   // The first long section also gets the output freeze, so the decoder
   // backs up and pushes back on the image side.
   task automatic push_hidden_bytes(input int unsigned count);
      logic [7:0] b;
      for (int unsigned i = 0; i < count; i++) begin
         if (i != 0 && i % 12 == 0) rotate_traffic();
         if (i == 0 && !hold_done && count >= 30) begin
            hold_done = 1'b1;
            freeze_start <= 1'b1;
            @(posedge clock);
            freeze_start <= 1'b0;
         end
         b = $urandom;
         if (i == 0)              b = 8'h00;
         else if (i == count - 1) b = 8'hFF;
         push_bits({24'd0, b}, 8);
      end
   endtask

   // waits until every image beat is taken and every result is back,
   // then lets the pipeline empty of beats that produce nothing
   task automatic wait_drained();
      do @(posedge clock);
      while (accepted_beats != pushed_beats || awaited_bytes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // call on a clock edge, with the decoder idle
   task automatic write_csr(input csr_index_type idx, input logic [15:0] val);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= val;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int unsigned shape;
      logic [15:0] skip_n;
      logic [15:0] magic_a;
      logic [15:0] magic_b;
      logic [15:0] junk;
      logic [7:0]  flip_a;
      logic [7:0]  flip_b;
      logic [31:0] ext_len;
      logic [31:0] pay_len;
      int unsigned pay_sent;
      string       frame_kind;

      req.valid      = 1'b0;
      req.pixel_byte = 8'h00;
      rsp.ready      = 1'b0;
      csr.valid      = 1'b0;
      csr.index      = CSR_HEADER_SKIP;
      csr.data       = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Header: extreme raw beats are swallowed by the default skip
      push_raw(8'h00);
      push_raw(8'hFF);
      push_raw(8'h01);
      push_raw(8'hFE);
      wait_drained();

      // magic writes during the header only matter once comparing starts
      write_csr(CSR_MAGIC_WORD, 16'h0000);
      write_csr(CSR_MAGIC_WORD, 16'hFFFF);
      // reloads the skip count mid-header
      write_csr(CSR_HEADER_SKIP, 16'hFFFF);
      push_noise(5);
      wait_drained();

      // either drop straight into the magic, or finish a short skip first
      if ($urandom_range(1) == 0) begin
         write_csr(CSR_HEADER_SKIP, 16'h0000);
      end else begin
         skip_n = $urandom_range(6, 1);
         write_csr(CSR_HEADER_SKIP, skip_n);
         push_noise(skip_n);
         wait_drained();
         write_csr(CSR_HEADER_SKIP, 16'h0000);
      end
      // past the header, a new skip count is ignored by the decoder
      junk = $urandom;
      write_csr(CSR_HEADER_SKIP, junk);

      // Magic: first byte against one setting, second against a rewrite
      shape = $urandom_range(15);
      case ($urandom_range(3))
         0:       magic_a = 16'h0000;
         1:       magic_a = 16'hFFFF;
         2:       magic_a = MAGIC_WORD_RESET;
         default: magic_a = $urandom;
      endcase
      write_csr(CSR_MAGIC_WORD, magic_a);
      flip_a = 8'h00;
      flip_b = 8'h00;
      if (shape < 2) begin
         if ($urandom_range(1) == 0) flip_a = 8'd1 << $urandom_range(7);
         else                        flip_b = 8'd1 << $urandom_range(7);
      end
      // a mismatch run has a single result beat, so the long hold-off starts
      // here and the error beat sits in the result register while beats queue
      if (shape < 2) begin
         hold_done = 1'b1;
         freeze_start <= 1'b1;
         @(posedge clock);
         freeze_start <= 1'b0;
      end
      push_bits({24'd0, magic_a[15:8] ^ flip_a}, 8);
      // halted on the first byte: keep the image side busy behind the error beat
      if (flip_a != 8'h00) push_noise(60);
      wait_drained();
      magic_b = $urandom;
      write_csr(CSR_MAGIC_WORD, magic_b);
      push_bits({24'd0, magic_b[7:0] ^ flip_b}, 8);

      // Frame body
      if (shape < 2) begin
         // halted: everything from here on must be silent
         frame_kind = "magic mismatch";
         repeat (4) begin
            push_noise(230);
            rotate_traffic();
         end
      end else begin
         case (shape)
            2, 3: begin
               frame_kind = "empty extension";
               ext_len    = 0;
               pay_len    = $urandom_range(120, 80);
               pay_sent   = pay_len;
            end
            4, 5: begin
               frame_kind = "empty payload";
               ext_len    = $urandom_range(120, 80);
               pay_len    = 0;
               pay_sent   = 0;
            end
            6: begin
               // all-ones length: the payload never ends within the run
               frame_kind = "unbounded payload";
               ext_len    = $urandom_range(8, 1);
               pay_len    = LEN_MASK;
               pay_sent   = 100;
            end
            default: begin
               frame_kind = "full frame";
               ext_len    = $urandom_range(24, 1);
               pay_len    = $urandom_range(115, 95);
               pay_sent   = pay_len;
            end
         endcase
         push_bits(ext_len, LEN_W);
         push_hidden_bytes(ext_len);
         push_bits(pay_len, LEN_W);
         push_hidden_bytes(pay_sent);
         // trailing image beats after the frame are ignored
         if (pay_sent == pay_len) begin
            rotate_traffic();
            push_noise(40);
         end
      end

      wait_drained();

      $display("Run: %s, %0d image beats, %0d hidden bytes and %0d error beats checked.",
               frame_kind, accepted_beats, checked_bytes, error_beats);
      $display("Image side back-pressured for %0d cycles during the output freeze.",
               stalled_cycles);
      if (fails == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
